@@ sv/psd_pkg.sv @@
// Shared types, constants and the control program for the prime signature distance block.
// Depends on nothing; the top level and its testbench import it.
`timescale 1ns / 1ps

package psd_pkg;

	// Fixed field widths and saturation limits of the result fields.
	localparam int IN_BITS    = 20;
	localparam int COUNT_BITS = 5;
	localparam int DIST_BITS  = 6;
	localparam int COUNT_MAX  = 31;
	localparam int DIST_MAX   = 63;

	// Program counter of the sequencer.
	localparam int STEP_BITS = 4;
	typedef logic [STEP_BITS-1:0] step_t;

	// Named steps of the control program.
	localparam step_t STEP_IDLE   = 4'd0;
	localparam step_t STEP_CHECK  = 4'd1;
	localparam step_t STEP_SQUARE = 4'd2;
	localparam step_t STEP_TEST   = 4'd3;
	localparam step_t STEP_DIVGO  = 4'd4;
	localparam step_t STEP_DIVWT  = 4'd5;
	localparam step_t STEP_UPDATE = 4'd6;
	localparam step_t STEP_ACCUM  = 4'd7;
	localparam step_t STEP_EMIT   = 4'd8;

	// Datapath action carried by one control word.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_INIT,
		OP_SQUARE,
		OP_DIV_GO,
		OP_UPDATE,
		OP_ACCUM,
		OP_EMIT
	} op_t;

	// Jump condition carried by one control word.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_ZERO,
		C_SQ_ABOVE,
		C_DIV_BUSY,
		C_DIVIDED
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	// Read-only control program: jump to target when the condition holds, else fall through.
	function automatic ucode_t ucode_fetch(input step_t step);
		ucode_t w;
		unique case (step)
			STEP_IDLE:   w = '{OP_LOAD,   C_NO_START, STEP_IDLE};
			STEP_CHECK:  w = '{OP_INIT,   C_ZERO,     STEP_EMIT};
			STEP_SQUARE: w = '{OP_SQUARE, C_NEVER,    STEP_IDLE};
			STEP_TEST:   w = '{OP_NOP,    C_SQ_ABOVE, STEP_EMIT};
			STEP_DIVGO:  w = '{OP_DIV_GO, C_NEVER,    STEP_IDLE};
			STEP_DIVWT:  w = '{OP_NOP,    C_DIV_BUSY, STEP_DIVWT};
			STEP_UPDATE: w = '{OP_UPDATE, C_DIVIDED,  STEP_DIVGO};
			STEP_ACCUM:  w = '{OP_ACCUM,  C_ALWAYS,   STEP_SQUARE};
			STEP_EMIT:   w = '{OP_EMIT,   C_ALWAYS,   STEP_IDLE};
			default:     w = '{OP_NOP,    C_ALWAYS,   STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ sv/psd_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on no package types; used twice by the top level.
`timescale 1ns / 1ps

module psd_div #(
	parameter int W = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CNTW = $clog2(W + 1);

	logic [CNTW-1:0] cnt_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    quo_q;
	logic [W:0]      trial;
	logic [W:0]      diff;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign busy  = (cnt_q != '0);

	// Bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ sv/prime_signature_distance.sv @@
// Top level of the prime signature distance block: sequencer, datapath and result register.
// Depends on psd_pkg and psd_div.
`timescale 1ns / 1ps

// Factors two operands by trial division and reports the number of distinct primes dividing
// either one and the sum of their absolute exponent differences. A transfer in happens when
// start is high and busy is low; the result appears in the cycle after the emit step, held
// for exactly one cycle with done high, and the receiver cannot stall it. A zero operand
// finishes with bad_input set. Otherwise each trial divisor (2, then odd values up to the
// square root of the larger remaining cofactor) goes through the pair of bit-serial
// dividers, run side by side on both cofactors, and again for every prime factor removed.
module prime_signature_distance #(
	parameter int VALUE_BITS = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [psd_pkg::IN_BITS-1:0]            first_value,
	input  logic [psd_pkg::IN_BITS-1:0]            second_value,
	output logic                                   done,
	output logic [psd_pkg::COUNT_BITS-1:0]         prime_count,
	output logic [psd_pkg::DIST_BITS-1:0]          exponent_distance,
	output logic                                   bad_input
);
	import psd_pkg::*;

	localparam int W  = VALUE_BITS;
	localparam int DW = (W + 1) / 2 + 1;
	localparam int EW = $clog2(W + 1);
	localparam int AW = $clog2(2 * W + 2);

	step_t              step_q;
	step_t              step_d;
	ucode_t             cw;
	logic               cond_hit;
	logic               accept;

	logic [W-1:0]       ra_q;
	logic [W-1:0]       rb_q;
	logic [W-1:0]       max_ab;
	logic [DW-1:0]      d_q;
	logic [2*DW-1:0]    sq_q;
	logic [EW-1:0]      ea_q;
	logic [EW-1:0]      eb_q;
	logic [EW-1:0]      e_diff;
	logic [AW-1:0]      count_q;
	logic [AW-1:0]      dist_q;
	logic [AW-1:0]      count_fin;
	logic [AW-1:0]      dist_fin;
	logic               any_zero;
	logic               a_left;
	logic               b_left;

	logic               div_go;
	logic               div_busy_a;
	logic               div_busy_b;
	logic [W-1:0]       quo_a;
	logic [W-1:0]       quo_b;
	logic [W-1:0]       rem_a;
	logic [W-1:0]       rem_b;
	logic               a_divides;
	logic               b_divides;

	logic               done_q;
	logic [COUNT_BITS-1:0] prime_count_q;
	logic [DIST_BITS-1:0]  exponent_distance_q;
	logic               bad_input_q;

	// Control word fetch and handshake.
	assign cw     = ucode_fetch(step_q);
	assign busy   = (step_q != STEP_IDLE);
	assign accept = start && !busy;
	assign div_go = (cw.op == OP_DIV_GO);

	// Datapath status used by the jump conditions.
	assign max_ab    = (ra_q > rb_q) ? ra_q : rb_q;
	assign any_zero  = (ra_q == '0) || (rb_q == '0);
	assign a_divides = (rem_a == '0);
	assign b_divides = (rem_b == '0);

	// Two dividers test the same trial divisor against both cofactors.
	psd_div #(.W(W)) u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go),
		.dividend  (ra_q),
		.divisor   (W'(d_q)),
		.busy      (div_busy_a),
		.quotient  (quo_a),
		.remainder (rem_a)
	);

	psd_div #(.W(W)) u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go),
		.dividend  (rb_q),
		.divisor   (W'(d_q)),
		.busy      (div_busy_b),
		.quotient  (quo_b),
		.remainder (rem_b)
	);

	// Jump condition select.
	always_comb begin
		unique case (cw.cond)
			C_NEVER:    cond_hit = 1'b0;
			C_ALWAYS:   cond_hit = 1'b1;
			C_NO_START: cond_hit = !start;
			C_ZERO:     cond_hit = any_zero;
			C_SQ_ABOVE: cond_hit = (sq_q > (2*DW)'(max_ab));
			C_DIV_BUSY: cond_hit = div_busy_a || div_busy_b;
			C_DIVIDED:  cond_hit = a_divides || b_divides;
			default:    cond_hit = 1'b1;
		endcase
	end

	// Next step: jump on a hit, else fall through to the following word.
	always_comb begin
		step_d = cond_hit ? cw.target : step_q + 1'b1;
	end

	// Exponent difference for the current trial divisor.
	assign e_diff = (ea_q > eb_q) ? (ea_q - eb_q) : (eb_q - ea_q);

	// Leftover cofactors above one are primes of exponent one; equal ones cancel.
	always_comb begin
		a_left    = (ra_q > W'(1));
		b_left    = (rb_q > W'(1));
		count_fin = count_q;
		dist_fin  = dist_q;
		if (a_left && b_left && (ra_q == rb_q)) begin
			count_fin = count_q + 1'b1;
		end else begin
			count_fin = count_q + AW'(a_left) + AW'(b_left);
			dist_fin  = dist_q + AW'(a_left) + AW'(b_left);
		end
	end

	// Step counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			done_q <= 1'b0;
		end else begin
			step_q <= step_d;
			done_q <= (cw.op == OP_EMIT);
		end
	end

	// Datapath registers driven by the current control word.
	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_LOAD: begin
				if (accept) begin
					ra_q    <= W'(first_value);
					rb_q    <= W'(second_value);
					count_q <= '0;
					dist_q  <= '0;
				end
			end
			OP_INIT: begin
				d_q <= DW'(2);
			end
			OP_SQUARE: begin
				sq_q <= (2*DW)'(d_q) * (2*DW)'(d_q);
				ea_q <= '0;
				eb_q <= '0;
			end
			OP_UPDATE: begin
				if (a_divides) begin
					ra_q <= quo_a;
					ea_q <= ea_q + 1'b1;
				end
				if (b_divides) begin
					rb_q <= quo_b;
					eb_q <= eb_q + 1'b1;
				end
			end
			OP_ACCUM: begin
				if ((ea_q != '0) || (eb_q != '0)) begin
					count_q <= count_q + 1'b1;
					dist_q  <= dist_q + AW'(e_diff);
				end
				d_q <= (d_q == DW'(2)) ? DW'(3) : d_q + DW'(2);
			end
			OP_EMIT: begin
				if (any_zero) begin
					prime_count_q       <= '0;
					exponent_distance_q <= '0;
					bad_input_q         <= 1'b1;
				end else begin
					prime_count_q <= (32'(count_fin) > 32'(COUNT_MAX))
						? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(count_fin);
					exponent_distance_q <= (32'(dist_fin) > 32'(DIST_MAX))
						? DIST_BITS'(DIST_MAX) : DIST_BITS'(dist_fin);
					bad_input_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign done              = done_q;
	assign prime_count       = prime_count_q;
	assign exponent_distance = exponent_distance_q;
	assign bad_input         = bad_input_q;

`ifndef SYNTHESIS
	// A result is shown for a single cycle only.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// An accepted transfer always makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer accepted but block not busy");

	// Dividers are never restarted while still working.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> (!div_busy_a && !div_busy_b))
		else $error("divider restarted while busy");

	// The step counter stays inside the program.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_EMIT)
		else $error("step counter outside the program");
`endif

endmodule

@@ bench/tb_prime_signature_distance.sv @@
// Self-checking testbench for prime_signature_distance: directed and random operand pairs,
// predicted by a local trial-division model and compared result by result.
// Depends on psd_pkg and the prime_signature_distance RTL.
`timescale 1ns / 1ps

module tb_prime_signature_distance;

	import psd_pkg::*;

	localparam int VALUE_BITS = 20;
	localparam longint unsigned VALUE_MASK = (64'd1 << VALUE_BITS) - 1;
	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_PAIRS = 100;
	// Pairs near the end of the run that are sent without idling.
	localparam int QUIET_TAIL = 15;
	// Cycle limit for the whole run; reaching it ends the bench with a failure.
	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int SETTLE_CYCLES = 100;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic [DIST_BITS-1:0]  distance;
		logic                  bad;
	} signature_t;

	typedef struct packed {
		logic [IN_BITS-1:0] a;
		logic [IN_BITS-1:0] b;
		logic               drain;
	} operand_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [IN_BITS-1:0] first_value = '0;
	logic [IN_BITS-1:0] second_value = '0;
	logic busy;
	logic done;
	logic [COUNT_BITS-1:0] prime_count;
	logic [DIST_BITS-1:0] exponent_distance;
	logic bad_input;

	operand_pair_t pending_pairs[$];
	signature_t expected_signatures[$];
	int error_count = 0;
	int cycle_count = 0;
	int accepted_count = 0;
	int total_pairs = 0;
	logic xfer_seen = 1'b0;
	int gap_left = 0;
	logic gap_on_idle = 1'b0;
	logic idle_mode = 1'b1;

	prime_signature_distance #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.first_value(first_value),
		.second_value(second_value),
		.done(done),
		.prime_count(prime_count),
		.exponent_distance(exponent_distance),
		.bad_input(bad_input)
	);

	always #HALF_PERIOD clk = ~clk;

	// Factors both operands by trial division and compares the exponents prime by prime.
	function automatic signature_t predict_signature(input logic [IN_BITS-1:0] a_in,
			input logic [IN_BITS-1:0] b_in);
		longint unsigned ra, rb, d, ea, eb, cnt, dst;
		signature_t s;
		ra = 64'(a_in);
		rb = 64'(b_in);
		ra = ra & VALUE_MASK;
		rb = rb & VALUE_MASK;
		s = '0;
		if (ra == 0 || rb == 0) begin
			s.bad = 1'b1;
			return s;
		end
		cnt = 0;
		dst = 0;
		for (d = 2; d * d <= ((ra > rb) ? ra : rb); d++) begin
			ea = 0;
			eb = 0;
			while (ra % d == 0) begin
				ra = ra / d;
				ea++;
			end
			while (rb % d == 0) begin
				rb = rb / d;
				eb++;
			end
			if (ea != 0 || eb != 0) begin
				cnt++;
				dst += (ea > eb) ? ea - eb : eb - ea;
			end
		end
		// A cofactor left above one is a prime; the same prime on both sides cancels.
		if (ra > 1 && rb > 1 && ra == rb) begin
			cnt++;
		end else begin
			if (ra > 1) begin
				cnt++;
				dst++;
			end
			if (rb > 1) begin
				cnt++;
				dst++;
			end
		end
		s.count = COUNT_BITS'((cnt > COUNT_MAX) ? COUNT_MAX : cnt);
		s.distance = DIST_BITS'((dst > DIST_MAX) ? DIST_MAX : dst);
		return s;
	endfunction

	// Product of a few random small primes, kept within the operand range.
	function automatic longint unsigned smooth_value(input int steps);
		longint unsigned v, p;
		v = 1;
		repeat (steps) begin
			case ($urandom_range(0, 7))
				0: p = 2;
				1: p = 3;
				2: p = 5;
				3: p = 7;
				4: p = 11;
				5: p = 13;
				6: p = 17;
				default: p = 19;
			endcase
			if (v * p <= VALUE_MASK) begin
				v = v * p;
			end
		end
		return v;
	endfunction

	// Nonzero value of a random bit length, so that most pairs factor quickly.
	function automatic longint unsigned short_value();
		int unsigned w;
		w = $urandom_range(1, VALUE_BITS);
		return 64'($urandom_range(1, (32'd1 << w) - 1));
	endfunction

	function automatic longint unsigned capped_product(input longint unsigned x,
			input longint unsigned y);
		return (x * y <= VALUE_MASK) ? x * y : x;
	endfunction

	task automatic add_pair(input longint unsigned a, input longint unsigned b,
			input logic drain);
		operand_pair_t item;
		item.a = a[IN_BITS-1:0];
		item.b = b[IN_BITS-1:0];
		item.drain = drain;
		pending_pairs.push_back(item);
	endtask

	task automatic report_error(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Driver: offers one pair at a time and holds it until the block takes the transfer.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			first_value <= '0;
			second_value <= '0;
			gap_left <= 0;
			gap_on_idle <= 1'b0;
			idle_mode <= 1'b1;
		end else if (start && !xfer_seen) begin
			// The offered pair has not been taken yet.
		end else if (gap_left > 0) begin
			start <= 1'b0;
			if (!gap_on_idle || !busy) begin
				gap_left <= gap_left - 1;
			end
		end else if (pending_pairs.size() != 0
				&& !(pending_pairs[0].drain && expected_signatures.size() != 0)) begin
			start <= 1'b1;
			first_value <= pending_pairs[0].a;
			second_value <= pending_pairs[0].b;
			pending_pairs.pop_front();
			// Idle bursts come and go in stretches and stop near the end of the run.
			if ($urandom_range(0, 9) == 0) begin
				idle_mode <= !idle_mode;
			end
			if (idle_mode && pending_pairs.size() > QUIET_TAIL && $urandom_range(0, 1)) begin
				gap_left <= $urandom_range(1, 12);
				gap_on_idle <= 1'($urandom_range(0, 1));
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: checks each result against the oldest prediction and predicts each new transfer.
	always @(posedge clk) begin
		signature_t want;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL prime_signature_distance");
			$finish;
		end else begin
			cycle_count <= cycle_count + 1;
			xfer_seen <= arst_n && start && !busy;
			if (arst_n && done) begin
				if (expected_signatures.size() == 0) begin
					report_error($sformatf("unexpected result count %0d distance %0d bad %0b",
						prime_count, exponent_distance, bad_input));
				end else begin
					want = expected_signatures.pop_front();
					if (prime_count !== want.count)
						report_error($sformatf("prime_count %0d, predicted %0d",
							prime_count, want.count));
					if (exponent_distance !== want.distance)
						report_error($sformatf("exponent_distance %0d, predicted %0d",
							exponent_distance, want.distance));
					if (bad_input !== want.bad)
						report_error($sformatf("bad_input %0b, predicted %0b",
							bad_input, want.bad));
				end
			end
			if (arst_n && start && !busy) begin
				expected_signatures.push_back(predict_signature(first_value, second_value));
				accepted_count <= accepted_count + 1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		longint unsigned a, b, c, p;
		int i;

		// Zero operands, ones and the extremes of the range.
		add_pair(0, 0, 1'b0);
		add_pair(0, 1048575, 1'b0);
		add_pair(1048575, 0, 1'b0);
		add_pair(1, 1, 1'b0);
		add_pair(1, 1048575, 1'b0);
		add_pair(1048575, 1048575, 1'b0);
		add_pair(1048575, 1048574, 1'b0);
		add_pair(2, 2, 1'b0);
		add_pair(2, 3, 1'b0);
		add_pair(12, 18, 1'b0);
		// High exponents on single primes.
		add_pair(524288, 531441, 1'b0);
		add_pair(524288, 1, 1'b0);
		// Seven distinct primes, alone and against themselves, and a power of ten.
		add_pair(510510, 1, 1'b0);
		add_pair(510510, 510510, 1'b0);
		add_pair(1000000, 1, 1'b0);
		// Large primes left over after trial division, different and equal.
		add_pair(999983, 1000003, 1'b0);
		add_pair(1048573, 1048573, 1'b0);
		add_pair(131042, 196563, 1'b0);
		add_pair(1048336, 65521, 1'b0);
		add_pair(1048573, 1, 1'b1);

		for (i = 0; i < RANDOM_PAIRS; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					a = $urandom & VALUE_MASK;
					b = $urandom & VALUE_MASK;
				end
				1: begin
					a = $urandom_range(0, 1) ? 0 : ($urandom & VALUE_MASK);
					b = (a == 0) ? ($urandom & VALUE_MASK) : 0;
				end
				2, 3: begin
					a = short_value();
					b = short_value();
				end
				4, 5, 6: begin
					// Shared small factors with different exponents on each side.
					c = smooth_value($urandom_range(0, 4));
					a = capped_product(smooth_value($urandom_range(0, 6)), c);
					b = capped_product(smooth_value($urandom_range(0, 6)), c);
				end
				7: begin
					// A common large prime that survives trial division on both sides.
					case ($urandom_range(0, 2))
						0: p = 1009;
						1: p = 4093;
						default: p = 65521;
					endcase
					a = capped_product(p, smooth_value($urandom_range(0, 3)));
					b = capped_product(p, smooth_value($urandom_range(0, 3)));
				end
				8: begin
					a = short_value();
					b = a;
				end
				default: begin
					a = 1;
					b = short_value();
					if ($urandom_range(0, 1)) begin
						a = b;
						b = 1;
					end
				end
			endcase
			add_pair(a, b, (i % 30) == 29);
		end
		total_pairs = pending_pairs.size();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_pairs) @(negedge clk);
		while (expected_signatures.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (error_count == 0) begin
			$display("PASS prime_signature_distance");
		end else begin
			$display("FAIL prime_signature_distance");
		end
		$finish;
	end

endmodule

@@ prime_signature_distance.f @@
sv/psd_pkg.sv
sv/psd_div.sv
sv/prime_signature_distance.sv
bench/tb_prime_signature_distance.sv
